>>> rtl/rplc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Proximity lock control package
// Shared widths, codes and channel payload types of the proximity lock block.
// ----------------------------------------------------------------------------
package rplc_pkg;

    localparam int WINDOW   = 5;
    localparam int SMP_W    = 8;
    localparam int AVG_W    = 16;
    localparam int FRAC_W   = 8;
    localparam int CD_W     = 26;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SMP_W + CNT_W;
    localparam int PR_W     = SMP_W + CNT_W + 1;
    localparam int MAG_W    = SUM_W + FRAC_W;
    localparam int DIV_R    = 4;
    localparam int DIV_CYC  = (MAG_W + DIV_R - 1) / DIV_R;
    localparam int DIV_PW   = DIV_CYC * DIV_R;
    localparam int DC_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int OP_W     = 4;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CD_W;

    localparam logic [CD_W-1:0] COOLDOWN_RESET = CD_W'(60000);
    localparam logic [CD_W-1:0] CNT_MAX        = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = CFG_IDX_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 4'd0,
        OP_SAMPLE     = 4'd1,
        OP_LOCK       = 4'd2,
        OP_UNLOCK     = 4'd3,
        OP_CONNECT    = 4'd4,
        OP_DISCONNECT = 4'd5,
        OP_PROX_ON    = 4'd6,
        OP_PROX_OFF   = 4'd7,
        OP_REPORT     = 4'd8
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOCKED   = 2'd0,
        KIND_UNLOCKED = 2'd1,
        KIND_REPORT   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [SMP_W-1:0] rssi_sample;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic                    by_proximity;
        logic                    notify;
        logic                    locked_now;
        logic signed [AVG_W-1:0] avg_rssi;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_item;

    typedef struct packed {
        logic  smp_write;
        logic  sum_step;
        logic  div_load;
        logic  div_step;
        logic  tick;
        logic  since_clear;
        logic  out_load;
        t_kind out_kind;
        logic  out_prox;
        logic  out_notify;
        logic  out_locked;
        logic  out_last;
        logic  out_use_avg;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_last;
        logic div_last;
        logic below;
        logic above;
        logic trig_nz;
        logic prox_ok;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> rtl/rplc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Proximity lock control channels
// Valid/ready channel interfaces for input items, results and register writes.
// ----------------------------------------------------------------------------
interface rplc_in_if;
    logic               valid;
    logic               ready;
    rplc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rplc_out_if;
    logic                valid;
    logic                ready;
    rplc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rplc_cfg_if;
    logic                valid;
    logic                ready;
    rplc_pkg::t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rplc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Proximity lock datapath
// Sample ring, serial sum, radix-16 divider, level compares, hold-off counter,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module rplc_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rplc_pkg::t_dp_cmd   i_cmd,
    output rplc_pkg::t_dp_sts        o_sts,
    input  wire logic signed [rplc_pkg::SMP_W-1:0] i_sample,
    input  wire logic                i_cfg_we,
    input  wire rplc_pkg::t_cfg_item i_cfg,
    output rplc_pkg::t_out_item      o_result
);

    logic signed [rplc_pkg::SMP_W-1:0] r_ring [rplc_pkg::WINDOW];
    logic [rplc_pkg::SLOT_W-1:0]       r_slot;
    logic                              r_full;
    logic [rplc_pkg::CNT_W-1:0]        r_cnt;
    logic [rplc_pkg::SLOT_W-1:0]       r_idx;
    logic signed [rplc_pkg::SUM_W-1:0] r_sum;
    logic [rplc_pkg::DIV_PW-1:0]       r_quo;
    logic [rplc_pkg::CNT_W-1:0]        r_rem;
    logic                              r_neg;
    logic [rplc_pkg::DC_W-1:0]         r_dcnt;
    logic signed [rplc_pkg::SMP_W-1:0] r_trigger;
    logic signed [rplc_pkg::SMP_W-1:0] r_release;
    logic [rplc_pkg::CD_W-1:0]         r_cooldown;
    logic [rplc_pkg::CD_W-1:0]         r_since;
    rplc_pkg::t_out_item               r_out;

    logic [rplc_pkg::SLOT_W-1:0]       w_slot_eff;
    logic [rplc_pkg::CNT_W-1:0]        w_slot_nxt;
    logic [rplc_pkg::SUM_W-1:0]        w_mag;
    logic [rplc_pkg::DIV_PW-1:0]       n_quo;
    logic [rplc_pkg::CNT_W-1:0]        n_rem;
    logic [rplc_pkg::AVG_W-1:0]        w_q16;
    logic signed [rplc_pkg::AVG_W-1:0] w_avg;
    logic signed [rplc_pkg::PR_W-1:0]  w_cnt_s;
    logic signed [rplc_pkg::PR_W-1:0]  w_rel_prod;
    logic signed [rplc_pkg::PR_W-1:0]  w_trg_prod;
    logic signed [rplc_pkg::PR_W-1:0]  w_sum_ext;

    assign w_slot_eff = (rplc_pkg::CNT_W'(r_slot) < rplc_pkg::CNT_W'(rplc_pkg::WINDOW))
                        ? r_slot : '0;
    assign w_slot_nxt = rplc_pkg::CNT_W'(w_slot_eff) + rplc_pkg::CNT_W'(1);
    assign w_mag      = r_sum[rplc_pkg::SUM_W-1] ? rplc_pkg::SUM_W'(-r_sum)
                                                 : rplc_pkg::SUM_W'(r_sum);

    always_comb begin
        logic [rplc_pkg::CNT_W:0] t;
        logic                     ge;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int j = 0; j < rplc_pkg::DIV_R; j++) begin
            t     = {n_rem, n_quo[rplc_pkg::DIV_PW-1]};
            ge    = (t >= {1'b0, r_cnt});
            n_rem = ge ? rplc_pkg::CNT_W'(t - {1'b0, r_cnt}) : t[rplc_pkg::CNT_W-1:0];
            n_quo = {n_quo[rplc_pkg::DIV_PW-2:0], ge};
        end
    end

    assign w_q16 = r_quo[rplc_pkg::AVG_W-1:0];
    assign w_avg = r_neg ? $signed(-w_q16) : $signed(w_q16);

    assign w_cnt_s    = $signed({{(rplc_pkg::PR_W-rplc_pkg::CNT_W){1'b0}}, r_cnt});
    assign w_rel_prod = rplc_pkg::PR_W'(r_release) * w_cnt_s;
    assign w_trg_prod = rplc_pkg::PR_W'(r_trigger) * w_cnt_s;
    assign w_sum_ext  = rplc_pkg::PR_W'(r_sum);

    assign o_sts.sum_last = (rplc_pkg::CNT_W'(r_idx) == (r_cnt - rplc_pkg::CNT_W'(1)));
    assign o_sts.div_last = (r_dcnt == '0);
    assign o_sts.below    = (w_sum_ext < w_rel_prod);
    assign o_sts.above    = (w_sum_ext > w_trg_prod);
    assign o_sts.trig_nz  = (r_trigger != '0);
    assign o_sts.prox_ok  = (r_cooldown == '0) || (r_since >= r_cooldown);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_full     <= 1'b0;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_dcnt     <= '0;
            r_trigger  <= '0;
            r_release  <= '0;
            r_cooldown <= rplc_pkg::COOLDOWN_RESET;
            r_since    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg.reg_idx)
                    rplc_pkg::CFG_TRIGGER:  r_trigger  <= i_cfg.wdata[rplc_pkg::SMP_W-1:0];
                    rplc_pkg::CFG_RELEASE:  r_release  <= i_cfg.wdata[rplc_pkg::SMP_W-1:0];
                    rplc_pkg::CFG_COOLDOWN: r_cooldown <= i_cfg.wdata[rplc_pkg::CD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.smp_write) begin
                r_idx <= '0;
                if (w_slot_nxt >= rplc_pkg::CNT_W'(rplc_pkg::WINDOW)) begin
                    r_slot <= '0;
                    r_full <= 1'b1;
                    r_cnt  <= rplc_pkg::CNT_W'(rplc_pkg::WINDOW);
                end else begin
                    r_slot <= rplc_pkg::SLOT_W'(w_slot_nxt);
                    r_cnt  <= r_full ? rplc_pkg::CNT_W'(rplc_pkg::WINDOW) : w_slot_nxt;
                end
            end
            if (i_cmd.sum_step) begin
                r_idx <= r_idx + rplc_pkg::SLOT_W'(1);
            end
            if (i_cmd.div_load) begin
                r_dcnt <= rplc_pkg::DC_W'(rplc_pkg::DIV_CYC - 1);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - rplc_pkg::DC_W'(1);
            end
            if (i_cmd.since_clear) begin
                r_since <= '0;
            end else if (i_cmd.tick && (r_since != rplc_pkg::CNT_MAX)) begin
                r_since <= r_since + rplc_pkg::CD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_write) begin
            r_ring[w_slot_eff] <= i_sample;
            r_sum              <= '0;
        end
        if (i_cmd.sum_step) begin
            r_sum <= r_sum + rplc_pkg::SUM_W'(r_ring[r_idx]);
        end
        if (i_cmd.div_load) begin
            r_quo <= rplc_pkg::DIV_PW'({w_mag, {rplc_pkg::FRAC_W{1'b0}}});
            r_rem <= '0;
            r_neg <= r_sum[rplc_pkg::SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_out.kind         <= i_cmd.out_kind;
            r_out.by_proximity <= i_cmd.out_prox;
            r_out.notify       <= i_cmd.out_notify;
            r_out.locked_now   <= i_cmd.out_locked;
            r_out.avg_rssi     <= i_cmd.out_use_avg ? w_avg : '0;
            r_out.last         <= i_cmd.out_last;
        end
    end

    assign o_result = r_out;

endmodule
`default_nettype wire

>>> rtl/rplc_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Proximity lock controller
// Sequences each request, holds the lock, link and mode flags, and decides
// which results a request produces and in what order.
// ----------------------------------------------------------------------------
module rplc_controller (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [rplc_pkg::OP_W-1:0]  i_op,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rplc_pkg::t_dp_cmd               o_cmd,
    input  wire rplc_pkg::t_dp_sts          i_sts
);

    rplc_pkg::t_state r_state, n_state;
    logic             r_locked, n_locked;
    logic             r_link, n_link;
    logic             r_auto, n_auto;
    logic             r_report, n_report;
    logic             r_need_rep, n_need_rep;
    logic             r_need_act, n_need_act;
    rplc_pkg::t_kind  r_act_kind, n_act_kind;
    logic             r_act_prox, n_act_prox;
    logic             r_act_avg, n_act_avg;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;
    logic             w_accept;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == rplc_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rplc_pkg::ST_IDLE;
            r_locked    <= 1'b1;
            r_link      <= 1'b0;
            r_auto      <= 1'b0;
            r_report    <= 1'b0;
            r_need_rep  <= 1'b0;
            r_need_act  <= 1'b0;
            r_act_kind  <= rplc_pkg::KIND_LOCKED;
            r_act_prox  <= 1'b0;
            r_act_avg   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_locked    <= n_locked;
            r_link      <= n_link;
            r_auto      <= n_auto;
            r_report    <= n_report;
            r_need_rep  <= n_need_rep;
            r_need_act  <= n_need_act;
            r_act_kind  <= n_act_kind;
            r_act_prox  <= n_act_prox;
            r_act_avg   <= n_act_avg;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_locked    = r_locked;
        n_link      = r_link;
        n_auto      = r_auto;
        n_report    = r_report;
        n_need_rep  = r_need_rep;
        n_need_act  = r_need_act;
        n_act_kind  = r_act_kind;
        n_act_prox  = r_act_prox;
        n_act_avg   = r_act_avg;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.out_kind = rplc_pkg::KIND_LOCKED;

        case (r_state)
            rplc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        rplc_pkg::OP_TICK: begin
                            o_cmd.tick = 1'b1;
                        end
                        rplc_pkg::OP_SAMPLE: begin
                            o_cmd.smp_write = 1'b1;
                            n_state = rplc_pkg::ST_SUM;
                        end
                        rplc_pkg::OP_LOCK, rplc_pkg::OP_UNLOCK: begin
                            n_need_act = 1'b1;
                            n_act_kind = (i_op == rplc_pkg::OP_LOCK) ? rplc_pkg::KIND_LOCKED
                                                                     : rplc_pkg::KIND_UNLOCKED;
                            n_act_prox = 1'b0;
                            n_act_avg  = 1'b0;
                            n_state    = rplc_pkg::ST_EMIT;
                        end
                        rplc_pkg::OP_CONNECT: begin
                            n_link = 1'b1;
                        end
                        rplc_pkg::OP_DISCONNECT: begin
                            n_link = 1'b0;
                            n_auto = 1'b0;
                            if (r_auto && !r_locked) begin
                                n_need_act = 1'b1;
                                n_act_kind = rplc_pkg::KIND_LOCKED;
                                n_act_prox = 1'b1;
                                n_act_avg  = 1'b0;
                                n_state    = rplc_pkg::ST_EMIT;
                            end
                        end
                        rplc_pkg::OP_PROX_ON: begin
                            n_auto = 1'b1;
                        end
                        rplc_pkg::OP_PROX_OFF: begin
                            n_auto = 1'b0;
                        end
                        rplc_pkg::OP_REPORT: begin
                            n_report = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            rplc_pkg::ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_last) begin
                    n_state = rplc_pkg::ST_DIV_LOAD;
                end
            end
            rplc_pkg::ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state = rplc_pkg::ST_DIV;
            end
            rplc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = rplc_pkg::ST_DECIDE;
                end
            end
            rplc_pkg::ST_DECIDE: begin
                n_need_rep = r_report;
                n_report   = 1'b0;
                n_act_prox = 1'b1;
                n_act_avg  = 1'b1;
                if (r_auto && i_sts.trig_nz && i_sts.prox_ok) begin
                    if (i_sts.below) begin
                        if (!r_locked) begin
                            n_need_act = 1'b1;
                            n_act_kind = rplc_pkg::KIND_LOCKED;
                        end
                    end else if (i_sts.above && r_locked) begin
                        n_need_act = 1'b1;
                        n_act_kind = rplc_pkg::KIND_UNLOCKED;
                    end
                end
                n_state = rplc_pkg::ST_EMIT;
            end
            rplc_pkg::ST_EMIT: begin
                if (!r_need_rep && !r_need_act) begin
                    n_state = rplc_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_notify = r_link;
                    n_out_valid      = 1'b1;
                    if (r_need_rep) begin
                        o_cmd.out_kind    = rplc_pkg::KIND_REPORT;
                        o_cmd.out_prox    = 1'b0;
                        o_cmd.out_locked  = r_locked;
                        o_cmd.out_use_avg = 1'b1;
                        o_cmd.out_last    = !r_need_act;
                        n_need_rep        = 1'b0;
                        if (!r_need_act) begin
                            n_state = rplc_pkg::ST_IDLE;
                        end
                    end else begin
                        o_cmd.out_kind    = r_act_kind;
                        o_cmd.out_prox    = r_act_prox;
                        o_cmd.out_locked  = (r_act_kind == rplc_pkg::KIND_LOCKED);
                        o_cmd.out_use_avg = r_act_avg;
                        o_cmd.out_last    = 1'b1;
                        o_cmd.since_clear = r_act_prox;
                        n_locked          = (r_act_kind == rplc_pkg::KIND_LOCKED);
                        n_need_act        = 1'b0;
                        n_state           = rplc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = rplc_pkg::ST_IDLE;
            end
        endcase
    end

    a_sample_starts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == rplc_pkg::OP_SAMPLE) |=> (r_state == rplc_pkg::ST_SUM))
        else $error("sample did not start the sum pass");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still held");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> (r_state == rplc_pkg::ST_IDLE))
        else $error("final result did not end the request");

    a_tick_keeps_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == rplc_pkg::OP_TICK) |=> $stable(r_locked))
        else $error("tick changed the lock state");

    a_report_not_proximity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.since_clear) |-> !r_need_rep)
        else $error("proximity action sent ahead of pending report");

endmodule
`default_nettype wire

>>> rtl/rssi_proximity_lock_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RSSI proximity lock control
// Smooths signal-strength samples over a ring of up to WINDOW entries and
// locks or unlocks on a hysteresis pair of levels, with a millisecond hold-off.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on i_in (op, rssi_sample) and results leave on o_out; both
// are valid/ready channels. Register writes enter on i_cfg, which is always
// ready, and must only be issued while no request is in progress.
// One request is worked on at a time. Tick, connect, mode and report requests
// produce no result; lock and unlock do, and so does disconnect while in
// proximity mode and unlocked. A sample is written to the ring, summed
// serially over the n samples averaged (1 to WINDOW), divided by n in DIV_CYC
// (5 here) radix-16 divider steps and compared with the levels; a pending
// report is emitted before any lock or unlock result that the sample causes.
// A result waits in the output register while the receiver stalls; the next
// request is taken meanwhile, but a result of its own waits until the register
// is free, and no further request is taken until then.
// Reset clears the sample history, selects locked, link down, proximity mode
// off, and loads the hold-off with its default of 60000 ms.
// ----------------------------------------------------------------------------
module rssi_proximity_lock_control (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rplc_in_if.sink     i_in,
    rplc_out_if.source  o_out,
    rplc_cfg_if.sink    i_cfg
);

    rplc_pkg::t_dp_cmd w_cmd;
    rplc_pkg::t_dp_sts w_sts;
    logic              w_cfg_we;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid && i_cfg.ready;

    rplc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.data.op),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rplc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_sample (i_in.data.rssi_sample),
        .i_cfg_we (w_cfg_we),
        .i_cfg    (i_cfg.data),
        .o_result (o_out.data)
    );

endmodule
`default_nettype wire
